// ===== rtl/sh3_pkg.sv =====
// shared constants, field widths and types for the cross-shaped sharpening stream
// no dependencies; imported by every module of the block

package sh3_pkg;

    // payload field widths
    localparam int PIX_W      = 8;
    localparam int ROW_W      = 12;
    localparam int IDX_W      = 13;
    localparam int TDATA_IN_W = 8;
    localparam int TDATA_W    = 40;

    // configuration port
    localparam int CFG_IW  = 2;
    localparam int CFG_DW  = 13;
    localparam int CW_W    = 12;
    localparam int CH_W    = 13;
    localparam int CC_W    = 3;

    localparam logic [CFG_IW-1:0] CFG_WIDTH_PIXELS  = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_HEIGHT_ROWS   = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_CHANNEL_COUNT = 2'd2;

    localparam logic [CW_W-1:0] RST_WIDTH_PIXELS  = 12'd640;
    localparam logic [CH_W-1:0] RST_HEIGHT_ROWS   = 13'd480;
    localparam logic [CC_W-1:0] RST_CHANNEL_COUNT = 3'd3;

    // default sizes
    localparam int MAX_LINE_BYTES_DEF = 8192;
    localparam int MAX_ROWS_DEF       = 4096;

    // position flags of one byte, from the counters to the datapath
    typedef struct packed {
        logic interior;
        logic frame_last;
    } t_pos_flags;

endpackage

// ===== rtl/sh3_pos.sv =====
// configuration registers, effective frame geometry and the row/byte counters
// depends on sh3_pkg

module sh3_pos import sh3_pkg::*; #(
    parameter int MAX_LINE_BYTES = MAX_LINE_BYTES_DEF,
    parameter int MAX_ROWS       = MAX_ROWS_DEF,
    parameter int AW             = $clog2(MAX_LINE_BYTES)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data,
    input  logic              i_advance,
    output logic [AW-1:0]     o_byte,
    output logic [AW-1:0]     o_right_addr,
    output logic [ROW_W-1:0]  o_out_row,
    output logic [CC_W-1:0]   o_chan,
    output t_pos_flags        o_flags
);

    localparam int LW   = $clog2(MAX_LINE_BYTES + 1);
    localparam int WW   = (LW > CW_W) ? LW : CW_W;
    localparam int RW   = $clog2(MAX_ROWS);
    localparam int HW   = $clog2(MAX_ROWS + 1);
    localparam int HCW  = (HW > CH_W) ? HW : CH_W;
    localparam int CAP1 = MAX_LINE_BYTES / 1;
    localparam int CAP2 = MAX_LINE_BYTES / 2;
    localparam int CAP3 = MAX_LINE_BYTES / 3;
    localparam int CAP4 = MAX_LINE_BYTES / 4;

    logic [CW_W-1:0] r_width;
    logic [CH_W-1:0] r_height;
    logic [CC_W-1:0] r_chan;
    logic [AW-1:0]   r_byte;
    logic [RW-1:0]   r_row;

    logic [CC_W-1:0] chan_eff;
    logic [WW-1:0]   cap;
    logic [WW-1:0]   w_sat;
    logic [WW-1:0]   w_eff;
    logic [WW-1:0]   len_prod;
    logic [LW-1:0]   len;
    logic [LW-1:0]   lim;
    logic [HCW-1:0]  h_sat;
    logic [HCW-1:0]  h_eff;
    logic [AW-1:0]   b_cur;
    logic [RW-1:0]   r_cur;
    logic [LW:0]     right_sum;
    logic [LW-1:0]   b_inc;
    logic [HCW-1:0]  r_inc;
    logic [AW-1:0]   n_byte;
    logic [RW-1:0]   n_row;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_WIDTH_PIXELS;
            r_height <= RST_HEIGHT_ROWS;
            r_chan   <= RST_CHANNEL_COUNT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WIDTH_PIXELS:  r_width  <= i_cfg_data[CW_W-1:0];
                CFG_HEIGHT_ROWS:   r_height <= i_cfg_data[CH_W-1:0];
                CFG_CHANNEL_COUNT: r_chan   <= i_cfg_data[CC_W-1:0];
                default: ;
            endcase
        end
    end

    // effective geometry
    always_comb begin
        if (r_chan == '0)
            chan_eff = CC_W'(1);
        else if (r_chan > CC_W'(4))
            chan_eff = CC_W'(4);
        else
            chan_eff = r_chan;

        unique case (chan_eff)
            CC_W'(1): cap = WW'(CAP1);
            CC_W'(2): cap = WW'(CAP2);
            CC_W'(3): cap = WW'(CAP3);
            default:  cap = WW'(CAP4);
        endcase

        w_sat    = (r_width < CW_W'(3)) ? WW'(3) : WW'(r_width);
        w_eff    = (w_sat > cap) ? cap : w_sat;
        len_prod = w_eff * WW'(chan_eff);
        len      = LW'(len_prod);
        lim      = len - LW'(chan_eff);

        h_sat = (r_height < CH_W'(3)) ? HCW'(3) : HCW'(r_height);
        h_eff = (h_sat > HCW'(MAX_ROWS)) ? HCW'(MAX_ROWS) : h_sat;
    end

    // current position, cleared if beyond a changed bound
    always_comb begin
        b_cur     = (LW'(r_byte) >= len) ? '0 : r_byte;
        r_cur     = (HCW'(r_row) >= h_eff) ? '0 : r_row;
        right_sum = (LW+1)'(b_cur) + (LW+1)'(chan_eff);
        o_right_addr = (right_sum >= (LW+1)'(MAX_LINE_BYTES)) ? '0 : AW'(right_sum);

        b_inc = LW'(b_cur) + LW'(1);
        r_inc = HCW'(r_cur) + HCW'(1);
        if (b_inc >= len) begin
            n_byte = '0;
            n_row  = (r_inc >= h_eff) ? '0 : RW'(r_inc);
        end else begin
            n_byte = AW'(b_inc);
            n_row  = r_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
            r_row  <= '0;
        end else if (i_advance) begin
            r_byte <= n_byte;
            r_row  <= n_row;
        end
    end

    assign o_byte    = b_cur;
    assign o_chan    = chan_eff;
    assign o_out_row = ROW_W'(r_cur - RW'(1));

    assign o_flags.interior = (r_cur >= RW'(2)) && (LW'(b_cur) >= LW'(chan_eff))
                              && (LW'(b_cur) < lim);
    assign o_flags.frame_last = (HCW'(r_cur) == h_eff - HCW'(1))
                                && (LW'(b_cur) == lim - LW'(1));

endmodule

// ===== rtl/sh3_line_mem.sv =====
// two line stores: middle line (previous row) and upper line (row before it)
// depends on sh3_pkg

module sh3_line_mem import sh3_pkg::*; #(
    parameter int DEPTH = MAX_LINE_BYTES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_addr,
    input  logic [AW-1:0]    i_right_addr,
    input  logic [PIX_W-1:0] i_lower,
    input  logic             i_up_we,
    input  logic [AW-1:0]    i_up_waddr,
    input  logic [PIX_W-1:0] i_up_wdata,
    output logic [PIX_W-1:0] o_centre,
    output logic [PIX_W-1:0] o_right,
    output logic [PIX_W-1:0] o_upper
);

    logic [PIX_W-1:0] mid_mem [DEPTH];
    logic [PIX_W-1:0] up_mem  [DEPTH];
    logic [PIX_W-1:0] r_centre;
    logic [PIX_W-1:0] r_right;
    logic [PIX_W-1:0] r_upper;

    // middle line: two reads, lower byte replaces the centre
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_centre       <= mid_mem[i_addr];
            r_right        <= mid_mem[i_right_addr];
            mid_mem[i_addr] <= i_lower;
        end
    end

    // upper line: centre moves up once it has been used
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_upper <= up_mem[i_addr];
        end
        if (i_up_we) begin
            up_mem[i_up_waddr] <= i_up_wdata;
        end
    end

    assign o_centre = r_centre;
    assign o_right  = r_right;
    assign o_upper  = r_upper;

endmodule

// ===== rtl/sh3_core.sv =====
// sharpening arithmetic: 5*centre minus the four neighbors, saturated to a byte
// depends on sh3_pkg

module sh3_core import sh3_pkg::*; (
    input  logic [PIX_W-1:0] i_centre,
    input  logic [PIX_W-1:0] i_left,
    input  logic [PIX_W-1:0] i_right,
    input  logic [PIX_W-1:0] i_upper,
    input  logic [PIX_W-1:0] i_lower,
    output logic [PIX_W-1:0] o_sharp
);

    logic [PIX_W+1:0] nb_sum;
    logic [PIX_W+2:0] centre5;
    logic [PIX_W+3:0] diff;

    always_comb begin
        nb_sum  = (PIX_W+2)'(i_left) + (PIX_W+2)'(i_right)
                + (PIX_W+2)'(i_upper) + (PIX_W+2)'(i_lower);
        centre5 = ((PIX_W+3)'(i_centre) << 2) + (PIX_W+3)'(i_centre);
        diff    = (PIX_W+4)'(centre5) - (PIX_W+4)'(nb_sum);
        if (diff[PIX_W+3])
            o_sharp = '0;
        else if (diff[PIX_W+2:PIX_W] != '0)
            o_sharp = '1;
        else
            o_sharp = diff[PIX_W-1:0];
    end

endmodule

// ===== rtl/sharpen_3x3_cross_stream.sv =====
// cross-shaped 3x3 sharpening filter on an interleaved-channel byte stream
// a result passes stage 1 and the output register after its lower neighbor is taken in
// throughput: one byte per cycle while the output is not stalled, set by one line store access per byte
// reset clears the counters and handshake state and loads the config defaults; the line stores are
// not cleared, so no clearing pass is needed and the first byte is taken right after reset
// depends on sh3_pkg, sh3_pos, sh3_line_mem, sh3_core

module sharpen_3x3_cross_stream import sh3_pkg::*; #(
    parameter int MAX_LINE_BYTES = MAX_LINE_BYTES_DEF,
    parameter int MAX_ROWS       = MAX_ROWS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // source bytes
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [TDATA_IN_W-1:0] i_s_tdata,   // [7:0] pixel_byte
    // sharpened bytes
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [TDATA_W-1:0]    o_m_tdata,   // [7:0] sharp_byte, [19:8] out_row,
                                               // [32:20] out_byte_index, [39:33] zero
    output logic                  o_m_tlast,   // frame_last
    // register writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IW-1:0]     i_cfg_index,
    input  logic [CFG_DW-1:0]     i_cfg_data
);

    localparam int AW = $clog2(MAX_LINE_BYTES);

    logic s_accept;
    logic s1_move;

    // position of the byte being taken in
    logic [AW-1:0]    pos_byte;
    logic [AW-1:0]    pos_right;
    logic [ROW_W-1:0] pos_out_row;
    logic [CC_W-1:0]  chan;
    t_pos_flags       pos_flags;

    // stage 1: line store read data plus the byte's context
    logic             r_s1_valid;
    logic [PIX_W-1:0] r_s1_lower;
    logic [AW-1:0]    r_s1_byte;
    logic [ROW_W-1:0] r_s1_row;
    t_pos_flags       r_s1_flags;

    logic [PIX_W-1:0] centre;
    logic [PIX_W-1:0] right;
    logic [PIX_W-1:0] upper;
    logic [PIX_W-1:0] left;
    logic [PIX_W-1:0] sharp;

    // last four centres handed on by stage 1, so the left neighbor needs no extra read port
    logic [PIX_W-1:0] r_hist [4];
    logic [1:0]       left_sel;

    // output register
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_sharp;
    logic [ROW_W-1:0] r_out_row;
    logic [IDX_W-1:0] r_out_idx;
    logic             r_out_last;

    // handshake: stage 1 drains into the output register whenever it is free
    assign s1_move    = r_s1_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_s1_valid || s1_move;
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    sh3_pos #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES),
        .MAX_ROWS       (MAX_ROWS),
        .AW             (AW)
    ) u_pos (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_advance    (s_accept),
        .o_byte       (pos_byte),
        .o_right_addr (pos_right),
        .o_out_row    (pos_out_row),
        .o_chan       (chan),
        .o_flags      (pos_flags)
    );

    // centre moves to the upper line when stage 1 hands it on
    sh3_line_mem #(
        .DEPTH (MAX_LINE_BYTES),
        .AW    (AW)
    ) u_mem (
        .i_clk        (i_clk),
        .i_rd_en      (s_accept),
        .i_addr       (pos_byte),
        .i_right_addr (pos_right),
        .i_lower      (i_s_tdata[PIX_W-1:0]),
        .i_up_we      (s1_move),
        .i_up_waddr   (r_s1_byte),
        .i_up_wdata   (centre),
        .o_centre     (centre),
        .o_right      (right),
        .o_upper      (upper)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_lower <= i_s_tdata[PIX_W-1:0];
            r_s1_byte  <= pos_byte;
            r_s1_row   <= pos_out_row;
            r_s1_flags <= pos_flags;
        end
    end

    // left neighbor: the centre seen one pixel (channel count bytes) earlier
    assign left_sel = 2'(chan - CC_W'(1));
    assign left     = r_hist[left_sel];

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_hist[0] <= centre;
            r_hist[1] <= r_hist[0];
            r_hist[2] <= r_hist[1];
            r_hist[3] <= r_hist[2];
        end
    end

    sh3_core u_core (
        .i_centre (centre),
        .i_left   (left),
        .i_right  (right),
        .i_upper  (upper),
        .i_lower  (r_s1_lower),
        .o_sharp  (sharp)
    );

    // border bytes pass stage 1 but leave the output register's valid low
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= r_s1_flags.interior;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_sharp <= sharp;
            r_out_row   <= r_s1_row;
            r_out_idx   <= IDX_W'(r_s1_byte);
            r_out_last  <= r_s1_flags.frame_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(TDATA_W - PIX_W - ROW_W - IDX_W)'(0), r_out_idx, r_out_row,
                         r_out_sharp};
    assign o_m_tlast  = r_out_last;

endmodule
